### src/sorted_region_table_macros.svh
// Assertion macros for the sorted region table.
// Included by the top level; depends on nothing else.
`ifndef SORTED_REGION_TABLE_MACROS_SVH
`define SORTED_REGION_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define SRT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sorted_region_table: assertion failed");
`define SRT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("sorted_region_table: forbidden condition seen");
`else
`define SRT_ASSERT(lbl, clk, rstn, prop)
`define SRT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### src/srt_pkg.sv
// Shared widths, codes and types of the sorted region table.
// Used by srt_cell and sorted_region_table; depends on nothing.
package srt_pkg;

  localparam int unsigned StartW              = 52;
  localparam int unsigned LenW                = 32;
  localparam int unsigned KindW               = 2;
  localparam int unsigned StatusW             = 2;
  localparam int unsigned CountOutW           = 7;
  localparam int unsigned DefaultTableEntries = 16;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PAGE   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERLAP   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT,
    CELL_LOAD_NEW,
    CELL_KEEP_LEFT,
    CELL_KEEP_RIGHT,
    CELL_TAKE_SPLIT
  } cell_op_e;

  typedef struct packed {
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
    logic              shared;
  } entry_t;

  typedef struct packed {
    logic [StartW-1:0] page;
    logic [LenW-1:0]   count;
    logic              shared;
  } cmd_t;

  typedef struct packed {
    logic le;
    logic hit;
    logic has_page;
    logic ovl;
    logic left_nz;
    logic right_nz;
  } cell_flags_t;

endpackage

### src/srt_cell.sv
// One cell of the region table: holds a single region, compares it against
// the request and shifts or reloads it. Depends on srt_pkg.
module srt_cell
  import srt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              eval_i,
  input  cell_op_e          op_i,
  input  cmd_t              cmd_i,
  input  logic              prev_le_i,
  input  logic              next_le_i,
  input  entry_t            prev_entry_i,
  input  entry_t            next_entry_i,
  input  logic [LenW-1:0]   prev_right_len_i,
  output logic              le_o,
  output entry_t            entry_o,
  output logic [LenW-1:0]   right_len_o,
  output cell_flags_t       flags_o
);

  entry_t              entry_q;
  cell_flags_t         flags_q;
  cell_flags_t         flags_d;
  logic [StartW:0]     end_w;
  logic [StartW:0]     cmd_end_w;
  logic [StartW:0]     page_w;
  logic [StartW:0]     start_w;
  logic [LenW-1:0]     left_len_w;

  // Region ends are one bit wider than a page number so they never wrap.
  assign start_w   = (StartW+1)'(entry_q.start);
  assign page_w    = (StartW+1)'(cmd_i.page);
  assign end_w     = start_w + (StartW+1)'(entry_q.len);
  assign cmd_end_w = page_w + (StartW+1)'(cmd_i.count);

  // The at-or-below flag runs down the row, so only the leading run of cells
  // counts. A split whose right part wraps to low pages can leave the table
  // out of order, and the insert point is still the first cell above.
  assign le_o = prev_le_i && valid_i && (entry_q.start <= cmd_i.page);

  // Both split lengths are below the region length, so 32-bit arithmetic holds.
  assign left_len_w  = cmd_i.page[LenW-1:0] - entry_q.start[LenW-1:0];
  assign right_len_o = entry_q.start[LenW-1:0] + entry_q.len
                       - cmd_i.page[LenW-1:0] - LenW'(1);

  always_comb begin
    flags_d.le       = le_o;
    flags_d.hit      = valid_i && (entry_q.start == cmd_i.page)
                       && (entry_q.len == cmd_i.count);
    flags_d.has_page = valid_i && (page_w >= start_w) && (page_w < end_w);
    // This cell is either the first region above the new start or the last
    // one at or below it; only those two can collide with a new region.
    flags_d.ovl      = (valid_i && !le_o && prev_le_i && (cmd_end_w > start_w))
                       || (le_o && !next_le_i && (end_w > page_w));
    flags_d.left_nz  = (page_w != start_w);
    flags_d.right_nz = ((page_w + (StartW+1)'(1)) != end_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (eval_i) begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      CELL_HOLD: begin
        entry_q <= entry_q;
      end
      CELL_TAKE_PREV: begin
        entry_q <= prev_entry_i;
      end
      CELL_TAKE_NEXT: begin
        entry_q <= next_entry_i;
      end
      CELL_LOAD_NEW: begin
        entry_q.start  <= cmd_i.page;
        entry_q.len    <= cmd_i.count;
        entry_q.shared <= cmd_i.shared;
      end
      CELL_KEEP_LEFT: begin
        entry_q.len <= left_len_w;
      end
      CELL_KEEP_RIGHT: begin
        entry_q.start <= cmd_i.page + StartW'(1);
        entry_q.len   <= right_len_o;
      end
      CELL_TAKE_SPLIT: begin
        entry_q.start  <= cmd_i.page + StartW'(1);
        entry_q.len    <= prev_right_len_i;
        entry_q.shared <= prev_entry_i.shared;
      end
      default: begin
        entry_q <= entry_q;
      end
    endcase
  end

  assign entry_o = entry_q;
  assign flags_o = flags_q;

endmodule

### src/sorted_region_table.sv
// Sorted region table: a row of srt_cell instances plus the controller that
// decides, per request, how each cell shifts or reloads. Depends on srt_pkg.
//
// Every request passes through S_EVAL and then S_APPLY once it is taken: in
// S_EVAL, all cells compare their region against the request in parallel and
// latch the outcome; in S_APPLY, the controller picks the hit and each cell
// holds, shifts toward or away from its neighbor or reloads in a single step,
// a page split included. The result appears on status_o, region_shared_o and
// entry_count_o with a one-cycle done_o strobe registered at the end of S_APPLY,
// and busy_o falls in that same cycle, so the next request can be taken while
// the strobe shows; no new request is taken before then, whatever the kind.
// The receiver cannot hold results off; done_o must be taken when it shows.
// entry_count_o keeps the current region count between requests.
`include "sorted_region_table_macros.svh"
module sorted_region_table
  import srt_pkg::*;
#(
  parameter int unsigned TableEntries = DefaultTableEntries
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [KindW-1:0]      kind_i,
  input  logic [StartW-1:0]     page_number_i,
  input  logic [LenW-1:0]       page_count_i,
  input  logic                  shared_i,
  output logic                  done_o,
  output logic [StatusW-1:0]    status_o,
  output logic                  region_shared_o,
  output logic [CountOutW-1:0]  entry_count_o
);

  localparam int unsigned N    = TableEntries;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam logic [CountOutW-1:0] FullCount = CountOutW'(TableEntries);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_e;

  state_e              state_q;
  kind_e               kind_q;
  cmd_t                cmd_q;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     count_d;
  logic                done_q;
  status_e             status_q;
  status_e             status_d;
  logic                rshared_q;
  logic                rshared_d;
  logic                accept_w;

  entry_t              entry_w   [N];
  logic [LenW-1:0]     rlen_w    [N];
  cell_flags_t         flags_w   [N];
  cell_op_e            op_w      [N];
  logic [N-1:0]        le_w;
  logic [N-1:0]        valid_w;

  assign accept_w = start_i && (state_q == S_IDLE);

  for (genvar j = 0; j < N; j++) begin : g_cell
    logic        prev_le;
    logic        next_le;
    entry_t      prev_entry;
    entry_t      next_entry;
    logic [LenW-1:0] prev_rlen;

    assign valid_w[j] = (count_q > CntW'(j));

    if (j == 0) begin : g_first
      assign prev_le    = 1'b1;
      assign prev_entry = '0;
      assign prev_rlen  = '0;
    end else begin : g_mid_prev
      assign prev_le    = le_w[j-1];
      assign prev_entry = entry_w[j-1];
      assign prev_rlen  = rlen_w[j-1];
    end

    if (j == N - 1) begin : g_last
      assign next_le    = 1'b0;
      assign next_entry = '0;
    end else begin : g_mid_next
      assign next_le    = le_w[j+1];
      assign next_entry = entry_w[j+1];
    end

    srt_cell u_cell (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .valid_i          (valid_w[j]),
      .eval_i           (state_q == S_EVAL),
      .op_i             (op_w[j]),
      .cmd_i            (cmd_q),
      .prev_le_i        (prev_le),
      .next_le_i        (next_le),
      .prev_entry_i     (prev_entry),
      .next_entry_i     (next_entry),
      .prev_right_len_i (prev_rlen),
      .le_o             (le_w[j]),
      .entry_o          (entry_w[j]),
      .right_len_o      (rlen_w[j]),
      .flags_o          (flags_w[j])
    );
  end

  always_comb begin
    logic [N-1:0] le_v;
    logic [N-1:0] prev_le_v;
    logic [N-1:0] hit_v;
    logic [N-1:0] has_v;
    logic [N-1:0] lnz_v;
    logic [N-1:0] rnz_v;
    logic [N-1:0] sh_v;
    logic [N-1:0] ovl_v;
    logic [N-1:0] mask;
    logic [N-1:0] hit_below;
    logic [N-1:0] has_below;
    logic [N-1:0] hit_first;
    logic [N-1:0] has_first;
    logic [N-1:0] has_first_prev;
    logic         sel_lnz;
    logic         sel_rnz;
    logic         sel_sh;
    logic         full;

    for (int j = 0; j < N; j++) begin
      le_v[j]  = flags_w[j].le;
      hit_v[j] = flags_w[j].hit;
      has_v[j] = flags_w[j].has_page;
      lnz_v[j] = flags_w[j].left_nz;
      rnz_v[j] = flags_w[j].right_nz;
      ovl_v[j] = flags_w[j].ovl;
      sh_v[j]  = entry_w[j].shared;
    end

    // Each cell learns whether a hit sits below it, so the first hit wins.
    for (int j = 0; j < N; j++) begin
      mask         = (N'(1) << j) - N'(1);
      hit_below[j] = |(hit_v & mask);
      has_below[j] = |(has_v & mask);
    end

    prev_le_v      = (le_v << 1) | N'(1);
    hit_first      = hit_v & ~hit_below;
    has_first      = has_v & ~has_below;
    has_first_prev = has_first << 1;
    sel_lnz        = |(has_first & lnz_v);
    sel_rnz        = |(has_first & rnz_v);
    sel_sh         = |(has_first & sh_v);
    full           = (count_q == CntW'(N));

    status_d  = ST_OK;
    count_d   = count_q;
    rshared_d = 1'b0;
    for (int j = 0; j < N; j++) begin
      op_w[j] = CELL_HOLD;
    end

    case (kind_q)
      KIND_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (|ovl_v) begin
          status_d = ST_OVERLAP;
        end else begin
          count_d = count_q + CntW'(1);
          for (int j = 0; j < N; j++) begin
            if (!le_v[j]) begin
              op_w[j] = prev_le_v[j] ? CELL_LOAD_NEW : CELL_TAKE_PREV;
            end
          end
        end
      end
      KIND_REMOVE: begin
        if (|hit_v) begin
          count_d = count_q - CntW'(1);
          for (int j = 0; j < N; j++) begin
            if (hit_first[j] || hit_below[j]) begin
              op_w[j] = CELL_TAKE_NEXT;
            end
          end
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      KIND_PAGE: begin
        if (!(|has_v)) begin
          status_d = ST_NOT_FOUND;
        end else if (sel_lnz && sel_rnz) begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            count_d   = count_q + CntW'(1);
            rshared_d = sel_sh;
            for (int j = 0; j < N; j++) begin
              if (has_first[j]) begin
                op_w[j] = CELL_KEEP_LEFT;
              end else if (has_first_prev[j]) begin
                op_w[j] = CELL_TAKE_SPLIT;
              end else if (has_below[j]) begin
                op_w[j] = CELL_TAKE_PREV;
              end
            end
          end
        end else if (sel_lnz || sel_rnz) begin
          rshared_d = sel_sh;
          for (int j = 0; j < N; j++) begin
            if (has_first[j]) begin
              op_w[j] = sel_lnz ? CELL_KEEP_LEFT : CELL_KEEP_RIGHT;
            end
          end
        end else begin
          // A single-page region vanishes entirely.
          count_d   = count_q - CntW'(1);
          rshared_d = sel_sh;
          for (int j = 0; j < N; j++) begin
            if (has_first[j] || has_below[j]) begin
              op_w[j] = CELL_TAKE_NEXT;
            end
          end
        end
      end
      KIND_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase

    if (state_q != S_APPLY) begin
      for (int j = 0; j < N; j++) begin
        op_w[j] = CELL_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      kind_q       <= kind_e'(kind_i);
      cmd_q.page   <= page_number_i;
      cmd_q.count  <= page_count_i;
      cmd_q.shared <= shared_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      status_q  <= ST_OK;
      rshared_q <= 1'b0;
      count_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          state_q   <= S_IDLE;
          done_q    <= 1'b1;
          status_q  <= status_d;
          rshared_q <= rshared_d;
          count_q   <= count_d;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign region_shared_o = rshared_q;
  assign entry_count_o   = CountOutW'(count_q);

  `SRT_ASSERT(a_accept_to_done, clk_i, rst_ni, start_i && !busy_o |-> ##3 done_o)
  `SRT_ASSERT_NEVER(a_done_while_busy, clk_i, rst_ni, done_o && busy_o)
  `SRT_ASSERT(a_full_means_full, clk_i, rst_ni, done_o && status_o == ST_FULL |-> entry_count_o == FullCount)
  `SRT_ASSERT(a_count_bound, clk_i, rst_ni, entry_count_o <= FullCount)

endmodule
